/* design/smacs_pkg.sv */
// ----------------------------------------------------------------------------
// smacs_pkg
// Shared types, codes and helpers for the simd multiply-accumulate by scalar
// ----------------------------------------------------------------------------
package smacs_pkg;

    localparam int NUM_REGS = 32;
    localparam int REG_AW   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DATA_W   = 64;
    localparam int LANE_W   = 32;

    localparam logic [1:0] FUNC_WR  = 2'd0;
    localparam logic [1:0] FUNC_RD  = 2'd1;
    localparam logic [1:0] FUNC_EXE = 2'd2;

    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_MLA = 2'd1;
    localparam logic [1:0] OP_MLS = 2'd2;

    localparam logic [1:0] ESZ_8  = 2'd0;
    localparam logic [1:0] ESZ_16 = 2'd1;
    localparam logic [1:0] ESZ_32 = 2'd2;

    typedef struct packed {
        logic       mul_en;
        logic [1:0] op;
        logic [1:0] esz;
    } t_lane_ctl;

    function automatic logic [REG_AW-1:0] f_wrap(input logic [5:0] n);
        return REG_AW'(n % NUM_REGS);
    endfunction

    function automatic logic [LANE_W-1:0] f_lane_mask(input logic [1:0] esz);
        logic [LANE_W-1:0] m;
        case (esz)
            ESZ_8:   m = 32'h0000_00ff;
            ESZ_16:  m = 32'h0000_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    function automatic logic [LANE_W-1:0] f_get_scalar(
        input logic [DATA_W-1:0] word,
        input logic [2:0]        lane,
        input logic [1:0]        esz
    );
        logic [LANE_W-1:0] s;
        case (esz)
            ESZ_8:   s = {24'd0, word[lane*8 +: 8]};
            ESZ_16:  s = {16'd0, word[lane[1:0]*16 +: 16]};
            default: s = word[lane[0]*32 +: 32];
        endcase
        return s;
    endfunction

endpackage

/* design/smacs_ram.sv */
// ----------------------------------------------------------------------------
// smacs_ram
// Generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module smacs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/smacs_lane_alu.sv */
// ----------------------------------------------------------------------------
// smacs_lane_alu
// Shared lane unit: registered lane-by-scalar product, then add/sub/pass
// ----------------------------------------------------------------------------
module smacs_lane_alu (
    input  logic                          i_clk,
    input  smacs_pkg::t_lane_ctl          i_ctl,
    input  logic [smacs_pkg::LANE_W-1:0]  i_src_lane,
    input  logic [smacs_pkg::LANE_W-1:0]  i_scalar,
    input  logic [smacs_pkg::LANE_W-1:0]  i_old_lane,
    output logic [smacs_pkg::LANE_W-1:0]  o_lane
);

    logic [smacs_pkg::LANE_W-1:0] w_mask;
    logic [smacs_pkg::LANE_W-1:0] w_src;
    logic [smacs_pkg::LANE_W-1:0] w_prod;
    logic [smacs_pkg::LANE_W-1:0] r_prod;
    logic [smacs_pkg::LANE_W-1:0] w_sum;

    assign w_mask = smacs_pkg::f_lane_mask(i_ctl.esz);
    assign w_src  = i_src_lane & w_mask;
    assign w_prod = w_src * i_scalar;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_prod;
        end
    end

    always_comb begin
        case (i_ctl.op)
            smacs_pkg::OP_MUL: w_sum = r_prod;
            smacs_pkg::OP_MLA: w_sum = i_old_lane + r_prod;
            default:           w_sum = i_old_lane - r_prod;
        endcase
    end

    assign o_lane = w_sum & w_mask;

endmodule

/* design/simd_multiply_accumulate_by_scalar.sv */
// ----------------------------------------------------------------------------
// simd_multiply_accumulate_by_scalar
// Register file of 64-bit vectors with write, read and lane-by-scalar
// multiply / multiply-add / multiply-subtract requests
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   i_valid / o_stall    i_func .. i_reg_count
//  result    o_valid / i_stall    o_read_data
//
//  write, unused, zero-count execute: result loaded in the accept cycle
//  read: result through S_RDW and S_RESP
//  execute: S_SCAL, S_SRC, S_DST, S_MUL/S_ACC per lane, S_WB, S_NXT, S_RESP;
//  one lane at a time via the single lane multiplier and the one ram read port
//  reset clears per-register valid bits, no clearing pass; the block is
//  ready right after reset; a stalled result holds and blocks new requests
// ----------------------------------------------------------------------------
module simd_multiply_accumulate_by_scalar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_reg_select,
    input  logic [63:0] i_write_data,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_element_size,
    input  logic [4:0]  i_dest_reg,
    input  logic [4:0]  i_src_reg,
    input  logic [4:0]  i_scalar_reg,
    input  logic [2:0]  i_scalar_lane,
    input  logic [1:0]  i_reg_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_read_data
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_RDW  = 10'b00_0000_0010,
        S_SCAL = 10'b00_0000_0100,
        S_SRC  = 10'b00_0000_1000,
        S_DST  = 10'b00_0001_0000,
        S_MUL  = 10'b00_0010_0000,
        S_ACC  = 10'b00_0100_0000,
        S_WB   = 10'b00_1000_0000,
        S_NXT  = 10'b01_0000_0000,
        S_RESP = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic                          r_out_valid;
    logic [63:0]                   r_out_data;
    logic [smacs_pkg::NUM_REGS-1:0] r_valid;
    logic                          r_rvld;

    logic [1:0]                    r_op, n_op;
    logic [1:0]                    r_esz, n_esz;
    logic [4:0]                    r_dreg, n_dreg;
    logic [4:0]                    r_sreg, n_sreg;
    logic [2:0]                    r_lane, n_lane;
    logic                          r_two, n_two;
    logic                          r_pair, n_pair;
    logic [31:0]                   r_scalar, n_scalar;
    logic [63:0]                   r_src, n_src;
    logic [63:0]                   r_dst, n_dst;
    logic [63:0]                   r_res, n_res;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_out_load;
    logic [63:0]                   w_out_value;
    logic                          w_we;
    logic [smacs_pkg::REG_AW-1:0]  w_waddr;
    logic [63:0]                   w_wdata;
    logic [smacs_pkg::REG_AW-1:0]  w_raddr;
    logic [63:0]                   w_ram_q;
    logic [63:0]                   w_rdata;
    logic [smacs_pkg::REG_AW-1:0]  w_src_addr;
    logic [smacs_pkg::REG_AW-1:0]  w_dst_addr;
    logic                          w_last_lane;
    smacs_pkg::t_lane_ctl          w_lane_ctl;
    logic [31:0]                   w_lane;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_valid && !o_stall;
    assign o_valid    = r_out_valid;
    assign o_read_data = r_out_data;

    assign w_rdata    = r_rvld ? w_ram_q : 64'd0;
    assign w_src_addr = smacs_pkg::f_wrap({1'b0, r_sreg} + {5'd0, r_pair});
    assign w_dst_addr = smacs_pkg::f_wrap({1'b0, r_dreg} + {5'd0, r_pair});

    always_comb begin
        case (r_esz)
            smacs_pkg::ESZ_8:  w_last_lane = (r_lane == 3'd7);
            smacs_pkg::ESZ_16: w_last_lane = (r_lane == 3'd3);
            default:           w_last_lane = (r_lane == 3'd1);
        endcase
    end

    smacs_ram #(
        .WIDTH (smacs_pkg::DATA_W),
        .DEPTH (smacs_pkg::NUM_REGS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    smacs_lane_alu u_alu (
        .i_clk      (i_clk),
        .i_ctl      (w_lane_ctl),
        .i_src_lane (r_src[31:0]),
        .i_scalar   (r_scalar),
        .i_old_lane (r_dst[31:0]),
        .o_lane     (w_lane)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_esz       = r_esz;
        n_dreg      = r_dreg;
        n_sreg      = r_sreg;
        n_lane      = r_lane;
        n_two       = r_two;
        n_pair      = r_pair;
        n_scalar    = r_scalar;
        n_src       = r_src;
        n_dst       = r_dst;
        n_res       = r_res;
        w_out_load  = 1'b0;
        w_out_value = 64'd0;
        w_we        = 1'b0;
        w_waddr     = w_dst_addr;
        w_wdata     = r_res;
        w_raddr     = w_src_addr;
        w_lane_ctl  = '{mul_en: 1'b0, op: r_op, esz: r_esz};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_func)
                        smacs_pkg::FUNC_WR: begin
                            w_we       = 1'b1;
                            w_waddr    = smacs_pkg::f_wrap({1'b0, i_reg_select});
                            w_wdata    = i_write_data;
                            w_out_load = 1'b1;
                        end
                        smacs_pkg::FUNC_RD: begin
                            w_raddr = smacs_pkg::f_wrap({1'b0, i_reg_select});
                            n_state = S_RDW;
                        end
                        smacs_pkg::FUNC_EXE: begin
                            if (i_reg_count != 2'd0) begin
                                w_raddr = smacs_pkg::f_wrap({1'b0, i_scalar_reg});
                                n_op    = i_operation;
                                n_esz   = i_element_size;
                                n_dreg  = i_dest_reg;
                                n_sreg  = i_src_reg;
                                n_lane  = i_scalar_lane;
                                n_two   = i_reg_count[1];
                                n_pair  = 1'b0;
                                n_state = S_SCAL;
                            end else begin
                                w_out_load = 1'b1;
                            end
                        end
                        default: begin
                            w_out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_RDW: begin
                n_res   = w_rdata;
                n_state = S_RESP;
            end
            S_SCAL: begin
                n_scalar = smacs_pkg::f_get_scalar(w_rdata, r_lane, r_esz);
                n_state  = S_SRC;
            end
            S_SRC: begin
                n_src   = w_rdata;
                w_raddr = w_dst_addr;
                n_state = S_DST;
            end
            S_DST: begin
                n_dst   = w_rdata;
                n_lane  = 3'd0;
                n_state = S_MUL;
            end
            S_MUL: begin
                w_lane_ctl.mul_en = 1'b1;
                n_state           = S_ACC;
            end
            S_ACC: begin
                case (r_esz)
                    smacs_pkg::ESZ_8: begin
                        n_res = {w_lane[7:0], r_res[63:8]};
                        n_src = {8'd0, r_src[63:8]};
                        n_dst = {8'd0, r_dst[63:8]};
                    end
                    smacs_pkg::ESZ_16: begin
                        n_res = {w_lane[15:0], r_res[63:16]};
                        n_src = {16'd0, r_src[63:16]};
                        n_dst = {16'd0, r_dst[63:16]};
                    end
                    default: begin
                        n_res = {w_lane, r_res[63:32]};
                        n_src = {32'd0, r_src[63:32]};
                        n_dst = {32'd0, r_dst[63:32]};
                    end
                endcase
                if (w_last_lane) begin
                    n_state = S_WB;
                end else begin
                    n_lane  = r_lane + 3'd1;
                    n_state = S_MUL;
                end
            end
            S_WB: begin
                w_we = 1'b1;
                if (r_two && !r_pair) begin
                    n_pair  = 1'b1;
                    n_state = S_NXT;
                end else begin
                    n_res   = 64'd0;
                    n_state = S_RESP;
                end
            end
            S_NXT: begin
                n_state = S_SRC;
            end
            S_RESP: begin
                if (w_out_free) begin
                    w_out_load  = 1'b1;
                    w_out_value = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rvld   <= r_valid[w_raddr];
        r_op     <= n_op;
        r_esz    <= n_esz;
        r_dreg   <= n_dreg;
        r_sreg   <= n_sreg;
        r_lane   <= n_lane;
        r_two    <= n_two;
        r_pair   <= n_pair;
        r_scalar <= n_scalar;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_res    <= n_res;
        if (w_out_load) begin
            r_out_data <= w_out_value;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_state == S_IDLE))
        else $error("request accepted while busy");

    a_write_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_IDLE && w_accept) || r_state == S_WB))
        else $error("register write outside idle or write-back");

    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || !i_stall))
        else $error("result loaded over a pending result");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && !(r_two && !r_pair))
            |=> (r_state == S_RESP && r_res == 64'd0))
        else $error("execute result not zero");
`endif

endmodule
